/* hdl/csf_pkg.sv */
// ----------------------------------------------------------------------------
// csf_pkg
// shared types, register indexes and limits for the column strip finder
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int CSF_MAX_ROWS = 1024;
  localparam int CSF_MAX_COLS = 1024;

  localparam int GEO_W    = 13;
  localparam int CFG_W    = 11;
  localparam int STEP_W   = 7;
  localparam int DARK_W   = 12;
  localparam int LIT_W    = 11;
  localparam int COORD_W  = 16;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QLVL_W   = $clog2(QDEPTH + 1);

  localparam logic [DARK_W-1:0] DARK_MAX = '1;
  localparam logic [LIT_W-1:0]  LIT_MAX  = '1;

  localparam logic [1:0] REG_MIN_GAP    = 2'd0;
  localparam logic [1:0] REG_STEP       = 2'd1;
  localparam logic [1:0] REG_COL_HEIGHT = 2'd2;
  localparam logic [1:0] REG_ROW_WIDTH  = 2'd3;

  localparam logic [CFG_W-1:0]  RST_MIN_GAP    = 11'd1;
  localparam logic [STEP_W-1:0] RST_STEP       = 7'd1;
  localparam logic [CFG_W-1:0]  RST_COL_HEIGHT = 11'd1024;
  localparam logic [CFG_W-1:0]  RST_ROW_WIDTH  = 11'd1024;

  typedef struct packed {
    logic [CFG_W-1:0]  min_gap;
    logic [STEP_W-1:0] step;
    logic [CFG_W-1:0]  col_height;
    logic [CFG_W-1:0]  row_width;
  } csf_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] strip_x;
    logic signed [COORD_W-1:0] strip_y;
    logic signed [COORD_W-1:0] half_height;
    logic                      last_of_item;
  } csf_res_t;

  typedef struct packed {
    logic     v1;
    logic     v2;
    csf_res_t r1;
    csf_res_t r2;
  } csf_push_t;

  // clamp a geometry register to 1..cap
  function automatic logic [GEO_W-1:0] eff_limit(input logic [CFG_W-1:0] v,
                                                 input logic [GEO_W-1:0] cap);
    logic [GEO_W-1:0] ext;
    ext = GEO_W'(v);
    if (v == '0) begin
      return GEO_W'(1);
    end else if (ext > cap) begin
      return cap;
    end
    return ext;
  endfunction

endpackage

/* hdl/csf_track.sv */
// ----------------------------------------------------------------------------
// csf_track
// per column run tracking and strip tests, up to two strips per pixel
// ----------------------------------------------------------------------------
module csf_track
  import csf_pkg::*;
#(
  parameter int MAX_ROWS = CSF_MAX_ROWS,
  parameter int MAX_COLS = CSF_MAX_COLS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  logic      lit,
  input  csf_cfg_t  cfg,
  output csf_push_t push
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  logic [DARK_W-1:0] dark_prev_run_r, dark_prev_run_nxt;
  logic [DARK_W-1:0] dark_run_r, dark_run_nxt;
  logic [LIT_W-1:0]  lit_prev_run_r, lit_prev_run_nxt;
  logic [LIT_W-1:0]  lit_run_r, lit_run_nxt;
  logic [RW-1:0]     row_count_r, row_count_nxt;
  logic [CW-1:0]     col_count_r, col_count_nxt;

  logic [DARK_W-1:0] dp1, dr1, dr2, gap12;
  logic [LIT_W-1:0]  lp1, lr1;
  logic [DARK_W:0]   dsum;
  logic [GEO_W-1:0]  h, w, row_inc, col_inc;
  logic              eoc, hit1, hit2;
  logic [5:0]        half;
  logic [COORD_W-1:0] hh1, hh2, x, diff1, diff2, y1, y2;

  always_comb begin
    gap12 = DARK_W'(cfg.min_gap);
    h     = eff_limit(cfg.col_height, GEO_W'(MAX_ROWS));
    w     = eff_limit(cfg.row_width, GEO_W'(MAX_COLS));

    dp1 = dark_prev_run_r;
    dr1 = dark_run_r;
    lp1 = lit_prev_run_r;
    lr1 = lit_run_r;
    hit1 = 1'b0;
    if (lit) begin
      if (lit_run_r == '0) begin
        hit1 = (dark_prev_run_r >= gap12) && (dark_run_r >= gap12) &&
               (lit_prev_run_r != '0);
        dp1  = dark_run_r;
        dr1  = '0;
      end
      lr1 = (lit_run_r == LIT_MAX) ? lit_run_r : lit_run_r + 1'b1;
    end else begin
      if (dark_run_r == '0) begin
        lp1 = lit_run_r;
        lr1 = '0;
      end
      dr1 = (dark_run_r == DARK_MAX) ? dark_run_r : dark_run_r + 1'b1;
    end

    row_inc = GEO_W'(row_count_r) + GEO_W'(1);
    col_inc = GEO_W'(col_count_r) + GEO_W'(1);
    eoc     = (row_inc >= h);
    dsum    = {1'b0, dr1} + (DARK_W + 1)'(cfg.min_gap);
    dr2     = dsum[DARK_W] ? DARK_MAX : dsum[DARK_W-1:0];
    hit2    = eoc && (dp1 >= gap12) && (dr2 >= gap12) && (lp1 != '0);

    half  = cfg.step[STEP_W-1:1];
    hh1   = COORD_W'(lit_prev_run_r) * COORD_W'(half);
    hh2   = COORD_W'(lp1) * COORD_W'(half);
    x     = COORD_W'(col_count_r) * COORD_W'(cfg.step) + COORD_W'(half);
    diff1 = COORD_W'(row_count_r) - COORD_W'(dark_run_r);
    diff2 = COORD_W'(row_count_r) + COORD_W'(1) + COORD_W'(cfg.min_gap) - COORD_W'(dr2);
    y1    = COORD_W'(diff1 * COORD_W'(cfg.step)) - hh1;
    y2    = COORD_W'(diff2 * COORD_W'(cfg.step)) - hh2;

    push.v1 = go && hit1;
    push.v2 = go && hit2;
    push.r1 = '{strip_x: x, strip_y: y1, half_height: hh1, last_of_item: !hit2};
    push.r2 = '{strip_x: x, strip_y: y2, half_height: hh2, last_of_item: 1'b1};

    if (eoc) begin
      dark_prev_run_nxt = '0;
      dark_run_nxt      = gap12;
      lit_prev_run_nxt  = '0;
      lit_run_nxt       = '0;
      row_count_nxt     = '0;
      col_count_nxt     = (col_inc >= w) ? '0 : CW'(col_inc);
    end else begin
      dark_prev_run_nxt = dp1;
      dark_run_nxt      = dr1;
      lit_prev_run_nxt  = lp1;
      lit_run_nxt       = lr1;
      row_count_nxt     = RW'(row_inc);
      col_count_nxt     = col_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_prev_run_r <= '0;
      dark_run_r      <= DARK_W'(RST_MIN_GAP);
      lit_prev_run_r  <= '0;
      lit_run_r       <= '0;
      row_count_r     <= '0;
      col_count_r     <= '0;
    end else if (go) begin
      dark_prev_run_r <= dark_prev_run_nxt;
      dark_run_r      <= dark_run_nxt;
      lit_prev_run_r  <= lit_prev_run_nxt;
      lit_run_r       <= lit_run_nxt;
      row_count_r     <= row_count_nxt;
      col_count_r     <= col_count_nxt;
    end
  end

endmodule

/* hdl/csf_outq.sv */
// ----------------------------------------------------------------------------
// csf_outq
// small result queue taking up to two strips per cycle, one out per cycle
// ----------------------------------------------------------------------------
module csf_outq
  import csf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  csf_push_t         push,
  input  logic              pop,
  output csf_res_t          head,
  output logic [QLVL_W-1:0] level
);

  csf_res_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QLVL_W-1:0] level_r, level_nxt;
  logic [QPTR_W-1:0] wa2;

  always_comb begin
    wa2       = push.v1 ? wp_r + 1'b1 : wp_r;
    wp_nxt    = wp_r + QPTR_W'(push.v1) + QPTR_W'(push.v2);
    rp_nxt    = rp_r + QPTR_W'(pop);
    level_nxt = level_r + QLVL_W'(push.v1) + QLVL_W'(push.v2) - QLVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v1) begin
      mem[wp_r] <= push.r1;
    end
    if (push.v2) begin
      mem[wa2] <= push.r2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  assign head  = mem[rp_r];
  assign level = level_r;

endmodule

/* hdl/column_strip_finder_top.sv */
// ----------------------------------------------------------------------------
// column_strip_finder_top
// finds vertical lit strips in a column-major binary pixel stream
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_pixel
//   out      output     out_valid / out_ready   out_strip_x, out_strip_y,
//                                               out_half_height, out_last_of_item
//   cfg      input      cfg_we                  cfg_idx, cfg_wdata
//
// one pixel per cycle while the result queue has room; a pixel is held in the
// input register until it is processed, and its strips then enter the result
// queue, which offers one strip per cycle while out_ready is high; a pixel ending
// a column may give two strips, which leave the result port one after the other;
// the input register waits while the result queue has fewer than two free entries
// reset is synchronous and clears counters, runs and registers to defaults
// ----------------------------------------------------------------------------
module column_strip_finder_top
  import csf_pkg::*;
#(
  parameter int MAX_ROWS = CSF_MAX_ROWS,
  parameter int MAX_COLS = CSF_MAX_COLS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_pixel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_strip_x,
  output logic signed [COORD_W-1:0] out_strip_y,
  output logic signed [COORD_W-1:0] out_half_height,
  output logic                      out_last_of_item,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_idx,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  csf_cfg_t          cfg_r;
  logic [7:0]        pix_r;
  logic              pix_vld_r;
  logic              go, pop;
  csf_push_t         push;
  csf_res_t          head;
  logic [QLVL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap    <= RST_MIN_GAP;
      cfg_r.step       <= RST_STEP;
      cfg_r.col_height <= RST_COL_HEIGHT;
      cfg_r.row_width  <= RST_ROW_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_GAP:    cfg_r.min_gap    <= cfg_wdata;
        REG_STEP:       cfg_r.step       <= cfg_wdata[STEP_W-1:0];
        REG_COL_HEIGHT: cfg_r.col_height <= cfg_wdata;
        REG_ROW_WIDTH:  cfg_r.row_width  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign go       = pix_vld_r && (level <= QLVL_W'(QDEPTH - 2));
  assign in_ready = !pix_vld_r || go;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= 1'b0;
    end else if (in_ready) begin
      pix_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_r <= in_pixel;
    end
  end

  csf_track #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_track (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .lit  (pix_r != '0),
    .cfg  (cfg_r),
    .push (push)
  );

  csf_outq u_outq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .level(level)
  );

  assign out_valid        = (level != '0);
  assign out_strip_x      = head.strip_x;
  assign out_strip_y      = head.strip_y;
  assign out_half_height  = head.half_height;
  assign out_last_of_item = head.last_of_item;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= QLVL_W'(QDEPTH))
    else $error("result queue overfilled");

  a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pix_vld_r && !go |=> pix_vld_r && $stable(pix_r))
    else $error("stalled pixel lost");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 && push.v2 |-> !push.r1.last_of_item && push.r2.last_of_item)
    else $error("last flag misplaced on double strip");

  a_push_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v1 || push.v2) |-> go && $past(level) <= QLVL_W'(QDEPTH))
    else $error("strip pushed without a processed pixel");

endmodule

/* bench/tb_column_strip_finder_top.sv */
// ----------------------------------------------------------------------------
// tb_column_strip_finder_top
// self-checking bench for the column strip finder
//
// pixels are streamed in column-major order through a bursty sender while the
// result port stalls on its own pattern; a scoreboard class keeps its own copy
// of the run counters and registers, predicts the strips of every accepted
// item and checks each strip that comes out, field by field, in order
// a directed part hits the register extremes and the edge cases, then random
// phases with fresh register settings run alternating dark and lit runs with
// some noise; registers only change once every predicted strip has arrived
// ----------------------------------------------------------------------------
module tb_column_strip_finder_top;
  import csf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_ORDER [4] = '{REG_MIN_GAP, REG_STEP, REG_COL_HEIGHT, REG_ROW_WIDTH};

  class strip_board;
    logic [CFG_W-1:0]  min_gap;
    logic [STEP_W-1:0] step;
    logic [CFG_W-1:0]  col_height;
    logic [CFG_W-1:0]  row_width;
    logic [DARK_W-1:0] dark_prev;
    logic [DARK_W-1:0] dark_cur;
    logic [LIT_W-1:0]  lit_prev;
    logic [LIT_W-1:0]  lit_cur;
    logic [CFG_W-1:0]  row_idx;
    logic [CFG_W-1:0]  col_idx;
    csf_res_t          item_strips[$];
    csf_res_t          strips_due[$];
    int                mismatches;
    int                pixels_seen;
    int                strips_checked;

    function new();
      min_gap    = RST_MIN_GAP;
      step       = RST_STEP;
      col_height = RST_COL_HEIGHT;
      row_width  = RST_ROW_WIDTH;
      row_idx    = '0;
      col_idx    = '0;
      mismatches = 0;
      pixels_seen = 0;
      strips_checked = 0;
      start_column();
    endfunction

    function void start_column();
      dark_prev = '0;
      dark_cur  = DARK_W'(min_gap);
      lit_prev  = '0;
      lit_cur   = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MIN_GAP:    min_gap    = val;
        REG_STEP:       step       = val[STEP_W-1:0];
        REG_COL_HEIGHT: col_height = val;
        REG_ROW_WIDTH:  row_width  = val;
        default: ;
      endcase
    endfunction

    function void try_strip(int unsigned end_row);
      int unsigned half;
      int unsigned hh;
      int unsigned x;
      int unsigned y;
      csf_res_t    r;
      if (dark_prev >= min_gap && dark_cur >= min_gap && lit_prev >= 1) begin
        half = step / 2;
        hh   = lit_prev * half;
        x    = col_idx * step + half;
        y    = (end_row - dark_cur) * step - hh;
        r.strip_x      = x[COORD_W-1:0];
        r.strip_y      = y[COORD_W-1:0];
        r.half_height  = hh[COORD_W-1:0];
        r.last_of_item = 1'b0;
        item_strips.push_back(r);
      end
    endfunction

    function void take_pixel(logic [7:0] px);
      int unsigned h;
      int unsigned w;
      int unsigned d;
      h = (col_height == 0) ? 1 : col_height;
      if (h > CSF_MAX_ROWS) h = CSF_MAX_ROWS;
      w = (row_width == 0) ? 1 : row_width;
      if (w > CSF_MAX_COLS) w = CSF_MAX_COLS;
      item_strips.delete();
      pixels_seen++;
      if (px != 0) begin
        if (lit_cur == 0) begin
          try_strip(row_idx);
          dark_prev = dark_cur;
          dark_cur  = '0;
        end
        if (lit_cur != LIT_MAX) lit_cur++;
      end else begin
        if (dark_cur == 0) begin
          lit_prev = lit_cur;
          lit_cur  = '0;
        end
        if (dark_cur != DARK_MAX) dark_cur++;
      end
      if (row_idx + 1 >= h) begin
        d = dark_cur + min_gap;
        dark_cur = (d > DARK_MAX) ? DARK_MAX : d[DARK_W-1:0];
        try_strip(row_idx + 1 + min_gap);
        row_idx = '0;
        if (col_idx + 1 >= w) col_idx = '0;
        else col_idx++;
        start_column();
      end else begin
        row_idx++;
      end
      if (item_strips.size() > 0) item_strips[item_strips.size()-1].last_of_item = 1'b1;
      foreach (item_strips[i]) strips_due.push_back(item_strips[i]);
    endfunction

    function void cmp_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_strip(csf_res_t got);
      csf_res_t want;
      if (strips_due.size() == 0) begin
        $display("%0t: unexpected strip, expected none actual x %0d y %0d hh %0d last %0d",
                 $time, got.strip_x, got.strip_y, got.half_height, got.last_of_item);
        mismatches++;
      end else begin
        want = strips_due.pop_front();
        strips_checked++;
        cmp_field("strip_x", want.strip_x, got.strip_x);
        cmp_field("strip_y", want.strip_y, got.strip_y);
        cmp_field("half_height", want.half_height, got.half_height);
        cmp_field("last_of_item", want.last_of_item, got.last_of_item);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_pixel = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_strip_x;
  logic signed [COORD_W-1:0] out_strip_y;
  logic signed [COORD_W-1:0] out_half_height;
  logic                      out_last_of_item;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_idx = REG_MIN_GAP;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  strip_board board = new();
  int         burst_left = 0;
  bit         idle_on = 1'b1;
  int         settings_used = 0;
  logic [9:0] stall_cnt = '0;

  column_strip_finder_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_strip_x      (out_strip_x),
    .out_strip_y      (out_strip_y),
    .out_half_height  (out_half_height),
    .out_last_of_item (out_last_of_item),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1'b1;
    case (stall_cnt[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (stall_cnt[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.take_pixel(in_pixel);
  end

  always @(posedge clk) begin
    csf_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.strip_x      = out_strip_x;
      got.strip_y      = out_strip_y;
      got.half_height  = out_half_height;
      got.last_of_item = out_last_of_item;
      board.match_strip(got);
    end
  end

  task automatic send_pixel(input logic [7:0] px);
    if (idle_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // lower valid, let every predicted strip drain, then cover the pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.strips_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_config(input logic [3:0] sel, input logic [CFG_W-1:0] mg,
                              input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] ht,
                              input logic [CFG_W-1:0] wd);
    logic [CFG_W-1:0] vals [4];
    vals = '{mg, st, ht, wd};
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_ORDER[i];
        cfg_wdata <= vals[i];
        @(posedge clk);
        board.write_reg(REG_ORDER[i], vals[i]);
      end
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // alternating dark and lit runs, first run lit, with some noise
  task automatic run_pixels(input int n_items, input int max_run, input int noise_pct);
    logic       lit;
    int         left;
    logic [7:0] px;
    lit  = 1'b0;
    left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) begin
        lit  = !lit;
        left = $urandom_range(1, max_run);
      end
      if ($urandom_range(0, 99) < noise_pct) px = 8'($urandom_range(0, 255));
      else px = lit ? 8'($urandom_range(1, 255)) : 8'h00;
      send_pixel(px);
      left--;
    end
  endtask

  task automatic send_list(input logic [7:0] seq[$]);
    foreach (seq[i]) send_pixel(seq[i]);
  endtask

  initial begin
    logic [CFG_W-1:0] mg;
    logic [CFG_W-1:0] st;
    logic [CFG_W-1:0] ht;
    logic [CFG_W-1:0] wd;
    logic [3:0]       sel;
    int               max_run;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset defaults: tall column, strip on lit start
    send_list('{8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'hAA, 8'h55, 8'h00});
    wait_drained();

    // zero gap, zero step, zero height and width
    apply_config(4'b1111, 11'd0, 11'd0, 11'd0, 11'd0);
    send_list('{8'h80, 8'h00, 8'h7F});
    wait_drained();

    // widest gap saturates the dark run, all-ones step field
    apply_config(4'b1111, 11'h7FF, 11'h7FF, 11'd4, 11'd2);
    send_list('{8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00});
    wait_drained();

    // oversize geometry, then shrink height and raise gap mid-column
    apply_config(4'b1111, 11'd1, 11'd2, 11'h7FF, 11'h7FF);
    send_list('{8'h01, 8'h00, 8'h02, 8'h00, 8'h00});
    wait_drained();
    apply_config(4'b0101, 11'd2, 11'd0, 11'd3, 11'd0);
    send_list('{8'h00, 8'h10, 8'h00});
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(0, 9))
        0: mg = 11'd0;
        1: mg = 11'h7FF;
        2: mg = 11'd1024;
        default: mg = 11'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
        0: st = 11'd0;
        1: st = 11'd127;
        default: st = 11'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
        0: ht = 11'd0;
        1: ht = 11'd1;
        2: ht = 11'($urandom_range(25, 60));
        default: ht = 11'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 7))
        0: wd = 11'd0;
        1: wd = 11'h7FF;
        default: wd = 11'($urandom_range(1, 6));
      endcase
      sel = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'b1111;
      idle_on = (p % 4 != 3);
      max_run = $urandom_range(1, 5) + ((board.min_gap < 4) ? board.min_gap : 3);
      apply_config(sel, mg, st, ht, wd);
      run_pixels(45, max_run, 10);
      wait_drained();
    end

    // walk far across the image so the center x wraps
    idle_on = 1'b1;
    apply_config(4'b1111, 11'd1, 11'd127, 11'd1, 11'h7FF);
    run_pixels(270, 4, 20);
    wait_drained();
    apply_config(4'b0100, 11'd0, 11'd0, 11'd2, 11'd0);
    run_pixels(40, 1, 0);
    wait_drained();

    repeat (10) @(posedge clk);
    $display("run covered %0d pixels and %0d strips over %0d register settings",
             board.pixels_seen, board.strips_checked, settings_used);
    if (board.mismatches == 0 && board.strips_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Some tests failed");
    $finish;
  end

endmodule
